FILE: src/rti_pkg.sv
// Shared constants and types for the ray/triangle intersection unit.
package rti_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned DIST_WIDTH      = 31;

  typedef enum logic [2:0] {
    OC_HIT      = 3'd0,
    OC_PARALLEL = 3'd1,
    OC_U_OUT    = 3'd2,
    OC_V_OUT    = 3'd3,
    OC_BEHIND   = 3'd4
  } outcome_e;

  typedef enum logic [2:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5
  } reg_idx_e;

endpackage

FILE: src/ray_triangle_intersect_unit.sv
// Pipelined exact fixed-point Moller-Trumbore ray/triangle test.
// Pipeline: 8 arithmetic stages, then 32 one-bit divider stages for the distance
// quotient.
// Throughput: one triangle per cycle; the whole pipeline holds while the
// output register is full and not taken.
// Reset (async, active low) clears all valid bits and the ray registers to 0.
module ray_triangle_intersect_unit #(
  parameter int unsigned COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = rti_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  logic [2:0]                                cfg_index_i,
  input  logic [COORD_WIDTH-1:0]                    cfg_data_i,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // distance, zero pad
  output logic [31:0]                               m_axis_tdata,
  // hit, outcome
  output logic [3:0]                                m_axis_tuser
);

  localparam int unsigned C    = COORD_WIDTH;
  localparam int unsigned EW   = C + 1;          // edge / offset width
  localparam int unsigned XW   = 2 * EW;         // cross partial product
  localparam int unsigned HW   = 2 * EW + 1;     // cross product result
  localparam int unsigned L    = EW;             // low split of HW operand
  localparam int unsigned PW   = EW + L + 1;     // dot partial product
  localparam int unsigned DW   = EW + HW + 2;    // dot product
  localparam int unsigned NW   = DW + FRAC_BITS + 2;
  localparam int unsigned RW   = NW + 32;        // divider remainder
  localparam int unsigned QW   = rti_pkg::DIST_WIDTH;
  localparam int unsigned NDIV = QW + 1;         // saturation bit + quotient bits
  localparam int unsigned NST  = 8 + NDIV;

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  // ray registers
  logic signed [C-1:0] cfg_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) cfg_q[i] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rti_pkg::REG_ORG_X: cfg_q[0] <= cfg_data_i;
        rti_pkg::REG_ORG_Y: cfg_q[1] <= cfg_data_i;
        rti_pkg::REG_ORG_Z: cfg_q[2] <= cfg_data_i;
        rti_pkg::REG_DIR_X: cfg_q[3] <= cfg_data_i;
        rti_pkg::REG_DIR_Y: cfg_q[4] <= cfg_data_i;
        rti_pkg::REG_DIR_Z: cfg_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [EW-1:0] dir_e [3];
  always_comb begin
    for (int k = 0; k < 3; k++) dir_e[k] = EW'(cfg_q[3+k]);
  end

  // valid shift line
  logic [NST:1] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-1:1], s_axis_tvalid};
    end
  end
  assign m_axis_tvalid = vld_q[NST];

  // stage 1: edges and origin offset
  logic signed [C-1:0]  vin [9];
  logic signed [EW-1:0] e1_1_q [3], e2_1_q [3], s_1_q [3];
  always_comb begin
    for (int k = 0; k < 9; k++) vin[k] = s_axis_tdata[k*C +: C];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1_1_q[k] <= EW'(vin[3+k]) - EW'(vin[k]);
        e2_1_q[k] <= EW'(vin[6+k]) - EW'(vin[k]);
        s_1_q[k]  <= EW'(cfg_q[k]) - EW'(vin[k]);
      end
    end
  end

  // stage 2: cross product partials, stage 3: cross products
  logic signed [XW-1:0] hp_q [3][2], qp_q [3][2];
  logic signed [EW-1:0] e1_2_q [3], e2_2_q [3], s_2_q [3];
  logic signed [HW-1:0] h_q [3], q_q [3];
  logic signed [EW-1:0] e1_3_q [3], e2_3_q [3], s_3_q [3];

  for (genvar k = 0; k < 3; k++) begin : g_cross
    localparam int unsigned J1 = (k + 1) % 3;
    localparam int unsigned J2 = (k + 2) % 3;
    always_ff @(posedge clk_i) begin
      if (en) begin
        hp_q[k][0] <= dir_e[J1] * e2_1_q[J2];
        hp_q[k][1] <= dir_e[J2] * e2_1_q[J1];
        qp_q[k][0] <= s_1_q[J1] * e1_1_q[J2];
        qp_q[k][1] <= s_1_q[J2] * e1_1_q[J1];
        e1_2_q[k]  <= e1_1_q[k];
        e2_2_q[k]  <= e2_1_q[k];
        s_2_q[k]   <= s_1_q[k];
        h_q[k]     <= HW'(hp_q[k][0]) - HW'(hp_q[k][1]);
        q_q[k]     <= HW'(qp_q[k][0]) - HW'(qp_q[k][1]);
        e1_3_q[k]  <= e1_2_q[k];
        e2_3_q[k]  <= e2_2_q[k];
        s_3_q[k]   <= s_2_q[k];
      end
    end
  end

  // stages 4-6: dot products a, U, V, T via split multiplies
  logic signed [EW-1:0] xs [4][3];
  logic signed [HW-1:0] ys [4][3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xs[0][k] = e1_3_q[k]; ys[0][k] = h_q[k];
      xs[1][k] = s_3_q[k];  ys[1][k] = h_q[k];
      xs[2][k] = dir_e[k];  ys[2][k] = q_q[k];
      xs[3][k] = e2_3_q[k]; ys[3][k] = q_q[k];
    end
  end

  logic signed [PW-1:0] pl_q [4][3], ph_q [4][3];
  logic signed [DW-1:0] fp_q [4][3];
  logic signed [DW-1:0] dot_q [4];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int d = 0; d < 4; d++) begin
        for (int k = 0; k < 3; k++) begin
          pl_q[d][k] <= xs[d][k] * $signed({1'b0, ys[d][k][L-1:0]});
          ph_q[d][k] <= xs[d][k] * $signed(ys[d][k][HW-1:L]);
          fp_q[d][k] <= (DW'(ph_q[d][k]) <<< L) + DW'(pl_q[d][k]);
        end
        dot_q[d] <= fp_q[d][0] + fp_q[d][1] + fp_q[d][2];
      end
    end
  end

  // stage 7: fold the determinant sign into all terms
  logic                 par_7_q;
  logic signed [DW-1:0] a_7_q, u_7_q, v_7_q, t_7_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      par_7_q <= (dot_q[0] == '0);
      if (dot_q[0][DW-1]) begin
        a_7_q <= -dot_q[0];
        u_7_q <= -dot_q[1];
        v_7_q <= -dot_q[2];
        t_7_q <= -dot_q[3];
      end else begin
        a_7_q <= dot_q[0];
        u_7_q <= dot_q[1];
        v_7_q <= dot_q[2];
        t_7_q <= dot_q[3];
      end
    end
  end

  // stage 8: bound tests, divider operands
  rti_pkg::outcome_e    oc_c;
  logic signed [DW:0]   uv_c;
  logic signed [NW-1:0] num_c, den_c;
  always_comb begin
    uv_c  = (DW+1)'(u_7_q) + (DW+1)'(v_7_q);
    num_c = (NW'(t_7_q) <<< (FRAC_BITS + 1)) + NW'(a_7_q);
    den_c = NW'(a_7_q) <<< 1;
    if (par_7_q) begin
      oc_c = rti_pkg::OC_PARALLEL;
    end else if (u_7_q < 0 || u_7_q > a_7_q) begin
      oc_c = rti_pkg::OC_U_OUT;
    end else if (v_7_q < 0 || uv_c > (DW+1)'(a_7_q)) begin
      oc_c = rti_pkg::OC_V_OUT;
    end else if (t_7_q <= 0) begin
      oc_c = rti_pkg::OC_BEHIND;
    end else begin
      oc_c = rti_pkg::OC_HIT;
    end
  end

  // divider pipeline: index 0 is stage 8, index j handles bit NDIV-j
  logic [RW-1:0]     dr_q  [NDIV];
  logic [RW-1:0]     dd_q  [NDIV];
  logic [QW-1:0]     dq_q  [1:NDIV];
  logic              ds_q  [1:NDIV];
  rti_pkg::outcome_e doc_q [NDIV+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dr_q[0]  <= RW'($unsigned(num_c));
      dd_q[0]  <= RW'($unsigned(den_c));
      doc_q[0] <= oc_c;
    end
  end

  for (genvar j = 1; j <= NDIV; j++) begin : g_div
    localparam int unsigned B = NDIV - j;
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = dd_q[j-1] << B;
    assign ge    = (trial <= dr_q[j-1]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        doc_q[j] <= doc_q[j-1];
      end
    end
    if (j == 1) begin : g_sat
      always_ff @(posedge clk_i) begin
        if (en) begin
          ds_q[j] <= ge;   // quotient at or above 2^31 saturates
          dq_q[j] <= '0;
        end
      end
    end else begin : g_bit
      always_ff @(posedge clk_i) begin
        if (en) begin
          ds_q[j] <= ds_q[j-1];
          dq_q[j] <= dq_q[j-1] | (ge ? (QW'(1) << B) : QW'(0));
        end
      end
    end
    if (j < NDIV) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en) begin
          dr_q[j] <= ge ? dr_q[j-1] - trial : dr_q[j-1];
          dd_q[j] <= dd_q[j-1];
        end
      end
    end
  end

  logic          hit;
  logic [QW-1:0] dist_out;
  assign hit      = (doc_q[NDIV] == rti_pkg::OC_HIT);
  assign dist_out = !hit ? '0 : (ds_q[NDIV] ? '1 : dq_q[NDIV]);
  assign m_axis_tdata = {1'b0, dist_out};
  assign m_axis_tuser = {doc_q[NDIV], hit};

  a_hit_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[3:1] == rti_pkg::OC_HIT)
    else $error("hit flag without hit outcome");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("miss with nonzero distance");

  a_code_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[3:1] <= rti_pkg::OC_BEHIND)
    else $error("outcome out of range");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> vld_q[1] == $past(vld_q[1]))
    else $error("first stage moved during stall");

endmodule
